// ===== hw/rtl/amf_pkg.sv =====
// ----------------------------------------------------------------------------
// amf_pkg
// Shared types and constants of the audio format sniffer: field widths,
// format codes and the magic tags.
// ----------------------------------------------------------------------------
package amf_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned FORMAT_W        = 3;
  localparam int unsigned SCANNED_W       = 11;
  localparam int unsigned SCAN_WINDOW_DEF = 1024;

  typedef enum logic [FORMAT_W-1:0] {
    FMT_UNKNOWN = 3'd0,
    FMT_MP3     = 3'd1,
    FMT_WAV     = 3'd2,
    FMT_AAC     = 3'd3,
    FMT_FLAC    = 3'd4
  } format_e;

  // Tags, offset 0 in the top byte.
  localparam logic [31:0] TAG_ID3  = {"ID3", 8'h00};
  localparam logic [31:0] TAG_RIFF = "RIFF";
  localparam logic [31:0] TAG_WAVE = "WAVE";
  localparam logic [31:0] TAG_FLAC = "fLaC";

  localparam logic [7:0] SYNC_BYTE  = 8'hFF;
  localparam logic [7:0] MPEG_MASK  = 8'hE0;
  localparam logic [7:0] ADTS_MASK  = 8'hF0;
  localparam logic [1:0] MPEG_VER_RSVD = 2'b01;
  localparam logic [1:0] MPEG_LAYER3   = 2'b01;

  function automatic logic [7:0] tag_byte(logic [31:0] tag, logic [1:0] idx);
    logic [31:0] sh;
    sh = tag << {idx, 3'b000};
    return sh[31:24];
  endfunction

endpackage

// ===== hw/rtl/amf_byte_if.sv =====
// ----------------------------------------------------------------------------
// amf_byte_if
// Stream byte channel: one byte per item with a last-byte flag.
// ----------------------------------------------------------------------------
interface amf_byte_if;
  import amf_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// ===== hw/rtl/amf_result_if.sv =====
// ----------------------------------------------------------------------------
// amf_result_if
// Result channel: detected format code and number of scanned bytes.
// ----------------------------------------------------------------------------
interface amf_result_if;
  import amf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [FORMAT_W-1:0]  format_code;
  logic [SCANNED_W-1:0] scanned_bytes;

  modport source (output valid, output format_code, output scanned_bytes, input ready);
  modport sink   (input valid, input format_code, input scanned_bytes, output ready);
endinterface

// ===== hw/rtl/amf_scan.sv =====
// ----------------------------------------------------------------------------
// amf_scan
// Per-stream match state. Folds one byte per step into the prefix and sync
// flags and decides the format from the updated flags.
// ----------------------------------------------------------------------------
module amf_scan #(
  parameter int unsigned SCAN_WINDOW = amf_pkg::SCAN_WINDOW_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic [amf_pkg::BYTE_W-1:0]     data_byte_i,
  input  logic                           final_byte_i,
  output amf_pkg::format_e               format_o,
  output logic [amf_pkg::SCANNED_W-1:0]  scanned_o
);
  import amf_pkg::*;

  localparam int unsigned PosW = $clog2(SCAN_WINDOW + 1);

  logic [PosW-1:0] pos_q, pos_d, pos_acc;
  logic [7:0]      rec0_q, rec1_q, rec2_q;
  logic [7:0]      rec0_d, rec1_d, rec2_d;
  logic            id3_q, riff_q, flac_q, mpeg_q, adts_q;
  logic            id3_d, riff_d, flac_d, mpeg_d, adts_d;
  logic            id3_acc, riff_acc, flac_acc, mpeg_acc, adts_acc;
  logic            in_win;
  logic [1:0]      idx;
  logic [1:0]      wave_idx;
  logic [1:0]      mpeg_ver, mpeg_layer;
  logic [PosW+SCANNED_W-1:0] pos_ext;

  assign in_win     = pos_q < PosW'(SCAN_WINDOW);
  assign idx        = pos_q[1:0];
  assign wave_idx   = 2'(pos_q - PosW'(8));
  assign mpeg_ver   = rec1_q[4:3];
  assign mpeg_layer = rec1_q[2:1];

  always_comb begin
    id3_acc  = id3_q;
    riff_acc = riff_q;
    flac_acc = flac_q;
    mpeg_acc = mpeg_q;
    adts_acc = adts_q;
    pos_acc  = pos_q;
    if (in_win) begin
      pos_acc = pos_q + PosW'(1);
      if (pos_q < PosW'(3) && data_byte_i != tag_byte(TAG_ID3, idx)) begin
        id3_acc = 1'b0;
      end
      if (pos_q < PosW'(4)) begin
        if (data_byte_i != tag_byte(TAG_RIFF, idx)) begin
          riff_acc = 1'b0;
        end
        if (data_byte_i != tag_byte(TAG_FLAC, idx)) begin
          flac_acc = 1'b0;
        end
      end
      if (pos_q >= PosW'(8) && pos_q < PosW'(12) &&
          data_byte_i != tag_byte(TAG_WAVE, wave_idx)) begin
        riff_acc = 1'b0;
      end
      if (pos_q >= PosW'(1) && rec0_q == SYNC_BYTE &&
          (data_byte_i & ADTS_MASK) == ADTS_MASK) begin
        adts_acc = 1'b1;
      end
      if (pos_q >= PosW'(3) && rec2_q == SYNC_BYTE && (rec1_q & MPEG_MASK) == MPEG_MASK &&
          mpeg_ver != MPEG_VER_RSVD && mpeg_layer == MPEG_LAYER3) begin
        mpeg_acc = 1'b1;
      end
    end
  end

  always_comb begin
    if (pos_acc < PosW'(4)) begin
      format_o = FMT_UNKNOWN;
    end else if (id3_acc || mpeg_acc) begin
      format_o = FMT_MP3;
    end else if (adts_acc) begin
      format_o = FMT_AAC;
    end else if (riff_acc && pos_acc >= PosW'(12)) begin
      format_o = FMT_WAV;
    end else if (flac_acc) begin
      format_o = FMT_FLAC;
    end else begin
      format_o = FMT_UNKNOWN;
    end
  end

  assign pos_ext   = {{SCANNED_W{1'b0}}, pos_acc};
  assign scanned_o = pos_ext[SCANNED_W-1:0];

  always_comb begin
    pos_d  = pos_q;
    rec0_d = rec0_q;
    rec1_d = rec1_q;
    rec2_d = rec2_q;
    id3_d  = id3_q;
    riff_d = riff_q;
    flac_d = flac_q;
    mpeg_d = mpeg_q;
    adts_d = adts_q;
    if (step_i) begin
      if (final_byte_i) begin
        pos_d  = '0;
        rec0_d = '0;
        rec1_d = '0;
        rec2_d = '0;
        id3_d  = 1'b1;
        riff_d = 1'b1;
        flac_d = 1'b1;
        mpeg_d = 1'b0;
        adts_d = 1'b0;
      end else begin
        pos_d  = pos_acc;
        id3_d  = id3_acc;
        riff_d = riff_acc;
        flac_d = flac_acc;
        mpeg_d = mpeg_acc;
        adts_d = adts_acc;
        if (in_win) begin
          rec0_d = data_byte_i;
          rec1_d = rec0_q;
          rec2_d = rec1_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      rec0_q <= '0;
      rec1_q <= '0;
      rec2_q <= '0;
      id3_q  <= 1'b1;
      riff_q <= 1'b1;
      flac_q <= 1'b1;
      mpeg_q <= 1'b0;
      adts_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      rec0_q <= rec0_d;
      rec1_q <= rec1_d;
      rec2_q <= rec2_d;
      id3_q  <= id3_d;
      riff_q <= riff_d;
      flac_q <= flac_d;
      mpeg_q <= mpeg_d;
      adts_q <= adts_d;
    end
  end

endmodule

// ===== hw/rtl/audio_format_magic_sniffer.sv =====
// ----------------------------------------------------------------------------
// audio_format_magic_sniffer
// Detects the audio format of a stream from its opening bytes.
//
// byte_i carries one stream byte per item, final_byte set on the last one.
// result_o carries one item per stream: format_code (0 unknown, 1 mp3,
// 2 wav, 3 aac, 4 flac) and scanned_bytes, the bytes examined, saturating
// at SCAN_WINDOW. Bytes past the window are ignored, but a final flag on
// one still ends the stream.
// An accepted byte lands in an input register; from there it updates the
// scan state and, for a final byte, the result is written to the output
// register at the same time, once that register is free or draining. One
// byte is taken every cycle; the only limit is the single output register,
// which a final byte needs free or draining.
// Reset empties both registers and returns the scan state to a fresh
// stream. While the receiver stalls, non-final bytes keep flowing; a final
// byte waits in the input register until the pending result is taken.
// ----------------------------------------------------------------------------
module audio_format_magic_sniffer #(
  parameter int unsigned SCAN_WINDOW = amf_pkg::SCAN_WINDOW_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  amf_byte_if.sink     byte_i,
  amf_result_if.source result_o
);
  import amf_pkg::*;

  logic                 s1_valid_q;
  logic [BYTE_W-1:0]    s1_byte_q;
  logic                 s1_final_q;
  logic                 s1_advance;
  logic                 out_free;
  logic                 out_valid_q;
  logic [FORMAT_W-1:0]  out_fmt_q;
  logic [SCANNED_W-1:0] out_cnt_q;
  format_e              scan_fmt;
  logic [SCANNED_W-1:0] scan_cnt;

  assign out_free     = !out_valid_q || result_o.ready;
  assign s1_advance   = s1_valid_q && (!s1_final_q || out_free);
  assign byte_i.ready = !s1_valid_q || s1_advance;

  amf_scan #(
    .SCAN_WINDOW (SCAN_WINDOW)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (s1_advance),
    .data_byte_i  (s1_byte_q),
    .final_byte_i (s1_final_q),
    .format_o     (scan_fmt),
    .scanned_o    (scan_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      s1_valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.ready && byte_i.valid) begin
      s1_byte_q  <= byte_i.data_byte;
      s1_final_q <= byte_i.final_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_advance && s1_final_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_advance && s1_final_q) begin
      out_fmt_q <= scan_fmt;
      out_cnt_q <= scan_cnt;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.format_code   = out_fmt_q;
  assign result_o.scanned_bytes = out_cnt_q;

endmodule

// ===== verif/audio_format_magic_sniffer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_format_magic_sniffer_test
// Self-checking bench for the audio format sniffer. A queue of stream bytes
// (directed headers first, then random streams built around ID3, MPEG,
// ADTS, RIFF/WAVE and fLaC patterns, some broken, truncated or past the
// scan window) feeds a clocked driver with random gaps. A scan model tracks
// every accepted byte and queues the format expected for each stream; a
// clocked monitor with random stalls checks each result against it.
// ----------------------------------------------------------------------------
module audio_format_magic_sniffer_test;
  import amf_pkg::*;

  localparam int unsigned WINDOW      = SCAN_WINDOW_DEF;
  localparam int unsigned BYTE_TARGET = 1550;
  localparam int unsigned MIN_STREAMS = 50;
  localparam int unsigned QUIET_LIMIT = 4000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [4:0] gap;
  } byte_item_t;

  typedef struct {
    format_e        code;
    logic [10:0]    count;
  } sniff_result_t;

  typedef struct {
    logic [10:0] pos;
    logic [7:0]  newest;
    logic [7:0]  middle;
    logic [7:0]  oldest;
    bit          id3_ok;
    bit          riff_ok;
    bit          flac_ok;
    bit          mpeg_seen;
    bit          adts_seen;
  } scan_state_t;

  typedef enum {
    SHAPE_ID3, SHAPE_MPEG, SHAPE_ADTS, SHAPE_RIFF, SHAPE_FLAC, SHAPE_NOISE
  } shape_e;

  logic clk_i;
  logic rst_ni;

  amf_byte_if   byte_ch ();
  amf_result_if res_ch ();

  audio_format_magic_sniffer #(
    .SCAN_WINDOW(WINDOW)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_ch),
    .result_o(res_ch)
  );

  byte_item_t    pending[$];
  sniff_result_t sniff_expected[$];
  scan_state_t   scan;
  byte_item_t    next_byte;

  int unsigned errors;
  int unsigned bytes_sent;
  int unsigned streams_done;
  int unsigned format_hits[5];
  int unsigned quiet_cycles;
  int unsigned hold_cnt;
  int unsigned stall_left;
  int unsigned stall_next;
  bit          sink_rush;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [7:0] tag_at(input logic [31:0] tag, input int unsigned idx);
    return tag[31 - 8 * idx -: 8];
  endfunction

  function automatic scan_state_t fresh_scan();
    scan_state_t s;
    s = '{pos: '0, newest: '0, middle: '0, oldest: '0, id3_ok: 1'b1,
          riff_ok: 1'b1, flac_ok: 1'b1, mpeg_seen: 1'b0, adts_seen: 1'b0};
    return s;
  endfunction

  function automatic void scan_byte(input logic [7:0] b);
    int unsigned p;
    logic [1:0]  ver;
    logic [1:0]  lyr;
    p = scan.pos;
    if (p < 3 && b != tag_at(TAG_ID3, p)) scan.id3_ok = 1'b0;
    if (p < 4) begin
      if (b != tag_at(TAG_RIFF, p)) scan.riff_ok = 1'b0;
      if (b != tag_at(TAG_FLAC, p)) scan.flac_ok = 1'b0;
    end
    if (p >= 8 && p < 12 && b != tag_at(TAG_WAVE, p - 8)) scan.riff_ok = 1'b0;
    if (p >= 1 && scan.newest == SYNC_BYTE && (b & ADTS_MASK) == ADTS_MASK)
      scan.adts_seen = 1'b1;
    if (p >= 3 && scan.oldest == SYNC_BYTE && (scan.middle & MPEG_MASK) == MPEG_MASK) begin
      ver = scan.middle[4:3];
      lyr = scan.middle[2:1];
      if (ver != MPEG_VER_RSVD && lyr == MPEG_LAYER3) scan.mpeg_seen = 1'b1;
    end
    scan.oldest = scan.middle;
    scan.middle = scan.newest;
    scan.newest = b;
    scan.pos    = scan.pos + 11'd1;
  endfunction

  function automatic format_e sniff_format();
    if (scan.pos < 4)                  return FMT_UNKNOWN;
    if (scan.id3_ok)                   return FMT_MP3;
    if (scan.mpeg_seen)                return FMT_MP3;
    if (scan.adts_seen)                return FMT_AAC;
    if (scan.riff_ok && scan.pos >= 12) return FMT_WAV;
    if (scan.flac_ok)                  return FMT_FLAC;
    return FMT_UNKNOWN;
  endfunction

  function automatic void track_byte(input logic [7:0] b, input logic last);
    sniff_result_t r;
    if (scan.pos < WINDOW) scan_byte(b);
    if (last) begin
      r.code  = sniff_format();
      r.count = scan.pos;
      sniff_expected.push_back(r);
      scan = fresh_scan();
    end
  endfunction

  task automatic queue_stream(input logic [7:0] bytes[$]);
    bit rush;
    rush = ($urandom_range(0, 3) == 0);
    foreach (bytes[i])
      pending.push_back('{bytes[i], (i == bytes.size() - 1),
                          rush ? 5'd0 : 5'($urandom_range(0, 19))});
  endtask

  task automatic queue_random_stream(input int unsigned len);
    logic [7:0]  s[$];
    logic [7:0]  pat[$];
    shape_e      shape;
    int unsigned at;
    int unsigned idx;
    int unsigned layers;
    for (int i = 0; i < len; i++) s.push_back(8'($urandom_range(0, 255)));
    layers = ($urandom_range(0, 3) == 0) ? 2 : 1;
    repeat (layers) begin
      shape = shape_e'($urandom_range(0, 5));
      pat.delete();
      at = 0;
      case (shape)
        SHAPE_ID3: begin
          for (int i = 0; i < 3; i++) pat.push_back(tag_at(TAG_ID3, i));
        end
        SHAPE_MPEG: begin
          pat.push_back(SYNC_BYTE);
          pat.push_back({3'b111, 2'($urandom_range(0, 3)),
                         ($urandom_range(0, 3) != 0) ? MPEG_LAYER3 : 2'($urandom_range(0, 3)),
                         1'($urandom_range(0, 1))});
          at = $urandom_range(0, len - 1);
        end
        SHAPE_ADTS: begin
          pat.push_back(SYNC_BYTE);
          pat.push_back({4'hF, 4'($urandom_range(0, 15))});
          at = $urandom_range(0, len - 1);
        end
        SHAPE_RIFF: begin
          for (int i = 0; i < 4; i++) pat.push_back(tag_at(TAG_RIFF, i));
          for (int i = 0; i < 4; i++) pat.push_back(8'($urandom_range(0, 255)));
          for (int i = 0; i < 4; i++) pat.push_back(tag_at(TAG_WAVE, i));
        end
        SHAPE_FLAC: begin
          for (int i = 0; i < 4; i++) pat.push_back(tag_at(TAG_FLAC, i));
        end
        default: ;
      endcase
      if (pat.size() != 0 && $urandom_range(0, 7) == 0) begin
        idx = $urandom_range(0, pat.size() - 1);
        pat[idx] = pat[idx] ^ (8'h01 << $urandom_range(0, 7));
      end
      foreach (pat[k])
        if (at + k < len) s[at + k] = pat[k];
    end
    queue_stream(s);
  endtask

  // stimulus, reset and end of run
  initial begin
    int unsigned counted;
    int unsigned made;
    int unsigned long_at;
    int unsigned len;
    byte_ch.valid      = 1'b0;
    byte_ch.data_byte  = '0;
    byte_ch.final_byte = 1'b0;
    res_ch.ready       = 1'b0;
    rst_ni             = 1'b0;
    scan               = fresh_scan();

    // short ID3 (unknown), MPEG v1 L3, ADTS, fLaC, RIFF/WAVE
    queue_stream({8'h49, 8'h44, 8'h33});
    queue_stream({8'hFF, 8'hFB, 8'h90, 8'h64});
    queue_stream({8'hFF, 8'hF1, 8'h50, 8'h80});
    queue_stream({8'h66, 8'h4C, 8'h61, 8'h43});
    queue_stream({8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'hFF, 8'h00, 8'h00,
                  8'h57, 8'h41, 8'h56, 8'h45});
    counted = 27;

    made    = 0;
    long_at = $urandom_range(0, 20);
    while (counted < BYTE_TARGET || made < MIN_STREAMS) begin
      if (made == long_at)
        len = $urandom_range(WINDOW - 2, WINDOW + 6);
      else if ($urandom_range(0, 3) == 0)
        len = $urandom_range(1, 5);
      else
        len = $urandom_range(6, 24);
      queue_random_stream(len);
      counted += (len < WINDOW) ? len : WINDOW;
      made++;
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending.size() != 0 || byte_ch.valid) @(posedge clk_i);
    while (sniff_expected.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sniff_expected.size() != 0) begin
      $error("%0d results never arrived", sniff_expected.size());
      errors++;
    end
    $display("Sent %0d bytes in %0d streams, including one about as long as the scan window.",
             bytes_sent, streams_done);
    $display("Results: unknown %0d, mp3 %0d, wav %0d, aac %0d, flac %0d.",
             format_hits[FMT_UNKNOWN], format_hits[FMT_MP3], format_hits[FMT_WAV],
             format_hits[FMT_AAC], format_hits[FMT_FLAC]);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_ch.valid      <= 1'b0;
      byte_ch.data_byte  <= '0;
      byte_ch.final_byte <= 1'b0;
      hold_cnt           <= 0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        track_byte(byte_ch.data_byte, byte_ch.final_byte);
        bytes_sent++;
        if (byte_ch.final_byte) streams_done++;
      end
      if (!byte_ch.valid || byte_ch.ready) begin
        if (pending.size() != 0 && hold_cnt >= pending[0].gap) begin
          next_byte = pending.pop_front();
          byte_ch.valid      <= 1'b1;
          byte_ch.data_byte  <= next_byte.data;
          byte_ch.final_byte <= next_byte.last;
          hold_cnt           <= 0;
        end else begin
          byte_ch.valid <= 1'b0;
          if (pending.size() != 0) hold_cnt <= hold_cnt + 1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (sniff_expected.size() == 0) begin
          $error("unexpected result: format_code %0d scanned_bytes %0d",
                 res_ch.format_code, res_ch.scanned_bytes);
          errors++;
        end else begin
          if (res_ch.format_code != sniff_expected[0].code) begin
            $error("format_code: expected %0d, got %0d",
                   sniff_expected[0].code, res_ch.format_code);
            errors++;
          end
          if (res_ch.scanned_bytes != sniff_expected[0].count) begin
            $error("scanned_bytes: expected %0d, got %0d",
                   sniff_expected[0].count, res_ch.scanned_bytes);
            errors++;
          end
          format_hits[sniff_expected[0].code]++;
          void'(sniff_expected.pop_front());
        end
        if ($urandom_range(0, 7) == 0) sink_rush = !sink_rush;
        stall_next = sink_rush ? 0 : $urandom_range(0, 19);
      end else begin
        stall_next = (stall_left != 0) ? stall_left - 1 : 0;
      end
      stall_left   <= stall_next;
      res_ch.ready <= (stall_next == 0);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $error("no item moved for %0d cycles", QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

endmodule

// ===== filelist.f =====
hw/rtl/amf_pkg.sv
hw/rtl/amf_byte_if.sv
hw/rtl/amf_result_if.sv
hw/rtl/amf_scan.sv
hw/rtl/audio_format_magic_sniffer.sv
verif/audio_format_magic_sniffer_test.sv
